// ===== src/tpdd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpdd_pkg: shared types and constants
// Mode codes, register indexes and fixed-point constants for the drive mixer.
// ----------------------------------------------------------------------------
package tpdd_pkg;

  typedef enum logic [1:0] {
    KIND_TURN  = 2'd0,
    KIND_WALL  = 2'd1,
    KIND_DEAD  = 2'd2,
    KIND_RESET = 2'd3
  } kind_e;

  localparam int unsigned NumRegs = 8;

  localparam logic [2:0] RegTurnKp = 3'd0;
  localparam logic [2:0] RegTurnKi = 3'd1;
  localparam logic [2:0] RegTurnKd = 3'd2;
  localparam logic [2:0] RegWallKp = 3'd3;
  localparam logic [2:0] RegWallKi = 3'd4;
  localparam logic [2:0] RegWallKd = 3'd5;
  localparam logic [2:0] RegFwdKp  = 3'd6;
  localparam logic [2:0] RegFwdKi  = 3'd7;

  localparam logic signed [15:0] FwdKd = 16'sd0;

  // Integral caps in Q12.4 units
  localparam logic signed [39:0] CapTurn = 40'sd32000;
  localparam logic signed [39:0] CapWall = 40'sd1600000;
  localparam logic signed [39:0] CapFwd  = 40'sd1600;
  localparam logic signed [39:0] IntegMin = {1'b1, 39'd0};

  localparam logic signed [7:0] ClampLim = 8'sd30;
  localparam logic [7:0]        StopPos  = 8'd90;

  // Output scale: num / 40960
  localparam logic [15:0] OutDiv = 16'd40960;

endpackage

// ===== src/triple_pid_differential_drive.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triple_pid_differential_drive
// Three PID loops (heading, wall, forward) mixed into two servo commands.
// ----------------------------------------------------------------------------
// A turn item runs the heading loop only, a dead-reckoning item the heading
// and wall loops, and a wall-follow item all three; a reset item clears the
// integrals and goes straight to the mix. Each loop that runs loads the
// error, updates the integral, does three multiply-accumulate steps on the
// one shared 40x16 multiplier, then scales, truncates and clamps. The mix
// follows the last loop. The scale by 1/40960 is a shift by 13 and a division
// by five done with a reciprocal multiply, in the same cycle as the clamp.
// in_stall_o stays high from acceptance until the result is loaded into the
// output register. The mix step holds while the previous result still waits
// there, so a stalled receiver lengthens the item by the length of the stall.
// The next item can be accepted in the cycle after the load. Configuration
// writes go straight into the gain registers and must only happen while the block is idle.
module triple_pid_differential_drive import tpdd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic signed [15:0] set_angle_i,
  input  logic signed [15:0] cur_angle_i,
  input  logic signed [15:0] set_dist_i,
  input  logic signed [15:0] cur_dist_i,
  input  logic signed [15:0] set_wall_dist_i,
  input  logic signed [15:0] cur_wall_dist_i,
  input  logic               direction_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         right_drive_o,
  output logic [7:0]         left_drive_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_INTEG, S_MUL_P, S_MUL_I, S_MUL_D, S_FIN, S_MIX, S_DONE
  } state_e;

  // Loop selector: 0 turn, 1 wall, 2 fwd
  localparam logic [1:0] LoopTurn = 2'd0;
  localparam logic [1:0] LoopWall = 2'd1;
  localparam logic [1:0] LoopFwd  = 2'd2;

  logic signed [15:0] regs_q [NumRegs];
  logic signed [39:0] integ_q [3];
  logic signed [16:0] prev_q  [3];

  state_e             state_q;
  logic [1:0]         kind_q;
  logic               dir_q;
  logic signed [15:0] set_q [3];
  logic signed [15:0] cur_q [3];
  logic [1:0]         loop_q;
  logic signed [16:0] err_q;
  logic signed [17:0] de_q;
  // num fits: |10*kp*e| < 2^37, |10*ki*I| < 2^58, |kd*de| < 2^33
  logic signed [59:0] acc_q;
  // magnitude and sign of the numerator
  logic [58:0]        dvd_q;
  logic               neg_q;
  logic signed [7:0]  tout_q, wout_q, fout_q;
  logic               out_valid_q;
  logic [7:0]         right_q, left_q;

  // ---- shared multiplier operands ----
  logic signed [39:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [55:0] mul_p;
  logic signed [15:0] kp, ki, kd;
  logic signed [39:0] cap;
  logic               add_neg;
  logic signed [16:0] err_w;
  logic signed [40:0] integ_sum;
  logic signed [39:0] integ_new;

  always_comb begin
    unique case (loop_q)
      LoopTurn: begin
        kp = regs_q[RegTurnKp]; ki = regs_q[RegTurnKi]; kd = regs_q[RegTurnKd];
        cap = CapTurn; add_neg = 1'b1;
      end
      LoopWall: begin
        kp = regs_q[RegWallKp]; ki = regs_q[RegWallKi]; kd = regs_q[RegWallKd];
        cap = CapWall; add_neg = 1'b0;
      end
      default: begin
        kp = regs_q[RegFwdKp]; ki = regs_q[RegFwdKi]; kd = FwdKd;
        cap = CapFwd; add_neg = 1'b0;
      end
    endcase
  end

  always_comb begin
    unique case (state_q)
      S_MUL_P: begin mul_a = 40'(err_q);     mul_b = kp; end
      S_MUL_I: begin mul_a = integ_q[loop_q]; mul_b = ki; end
      S_MUL_D: begin mul_a = 40'(de_q);      mul_b = kd; end
      default: begin mul_a = '0;             mul_b = '0; end
    endcase
    mul_p = mul_a * mul_b;
  end

  assign err_w     = 17'(set_q[loop_q]) - 17'(cur_q[loop_q]);
  assign integ_sum = 41'(integ_q[loop_q]) + 41'(err_q) * 41'sd10;
  assign integ_new = (integ_sum < 41'(IntegMin)) ? IntegMin : integ_sum[39:0];

  // Truncate |num| / 40960 as (|num| >> 13) / 5; divide by five with a
  // reciprocal multiply, and clamp anything from 155 up straight to 30.
  logic [45:0]       q_hi;
  logic [15:0]       q_rcp;
  logic [4:0]        q_mag;
  logic signed [7:0] q_clamped;
  always_comb begin
    q_hi      = dvd_q[58:13];
    q_rcp     = 16'(q_hi[7:0]) * 16'd205;
    q_mag     = (q_hi >= 46'd155) ? 5'(ClampLim) : q_rcp[14:10];
    q_clamped = neg_q ? -8'(q_mag) : 8'(q_mag);
  end

  logic signed [9:0] spd, rsum, lsum;
  assign spd  = (kind_q == KIND_WALL) ? 10'(fout_q)
              : (dir_q ? -10'(ClampLim) : 10'(ClampLim));
  assign rsum = 10'(StopPos) - spd + 10'(tout_q) + 10'(wout_q);
  assign lsum = 10'(StopPos) + spd + 10'(tout_q) + 10'(wout_q);

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_q && !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) regs_q[i] <= '0;
    end else if (cfg_we_i) begin
      regs_q[cfg_index_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        integ_q[i] <= '0;
        prev_q[i]  <= '0;
      end
      loop_q <= LoopTurn;
    end else begin
      // drop the result once taken, unless the mix step reloads it
      if (out_acc && state_q != S_MIX) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            kind_q   <= kind_i;
            dir_q    <= direction_i;
            set_q[0] <= set_angle_i;     cur_q[0] <= cur_angle_i;
            set_q[1] <= set_wall_dist_i; cur_q[1] <= cur_wall_dist_i;
            set_q[2] <= set_dist_i;      cur_q[2] <= cur_dist_i;
            loop_q   <= LoopTurn;
            tout_q   <= '0; wout_q <= '0; fout_q <= '0;
            if (kind_i == KIND_RESET) begin
              // clear the integrals, keep the last errors
              for (int i = 0; i < 3; i++) integ_q[i] <= '0;
              state_q <= S_MIX;
            end else begin
              state_q <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          err_q   <= err_w;
          de_q    <= 18'(err_w) - 18'(prev_q[loop_q]);
          state_q <= S_INTEG;
        end
        S_INTEG: begin
          if (integ_q[loop_q] < cap || (add_neg && err_q < 0))
            integ_q[loop_q] <= integ_new;
          prev_q[loop_q] <= err_q;
          acc_q   <= '0;
          state_q <= S_MUL_P;
        end
        S_MUL_P: begin
          acc_q   <= acc_q + 60'(mul_p) * 60'sd10;
          state_q <= S_MUL_I;
        end
        S_MUL_I: begin
          acc_q   <= acc_q + 60'(mul_p) * 60'sd10;
          state_q <= S_MUL_D;
        end
        S_MUL_D: begin
          // sign and magnitude of the full numerator
          neg_q   <= (acc_q + 60'(mul_p)) < 0;
          dvd_q   <= ((acc_q + 60'(mul_p)) < 0) ? 59'(-(acc_q + 60'(mul_p)))
                                                : 59'(acc_q + 60'(mul_p));
          state_q <= S_FIN;
        end
        S_FIN: begin
          unique case (loop_q)
            LoopTurn: tout_q <= q_clamped;
            LoopWall: wout_q <= q_clamped;
            default:  fout_q <= q_clamped;
          endcase
          // advance: turn, then fwd (wall follow only), then wall; a turn item stops after turn
          priority if (kind_q == KIND_TURN || loop_q == LoopWall) begin
            state_q <= S_MIX;
          end else if (loop_q == LoopTurn && kind_q == KIND_WALL) begin
            loop_q <= LoopFwd;  state_q <= S_LOAD;
          end else begin
            loop_q <= LoopWall; state_q <= S_LOAD;
          end
        end
        S_MIX: begin
          if (!out_valid_q || out_acc) begin
            out_valid_q <= 1'b1;
            if (kind_q == KIND_RESET) begin
              right_q <= StopPos; left_q <= StopPos;
            end else if (kind_q == KIND_TURN) begin
              right_q <= StopPos + 8'(tout_q);
              left_q  <= StopPos + 8'(tout_q);
            end else begin
              right_q <= rsum[7:0];
              left_q  <= lsum[7:0];
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign right_drive_o = right_q;
  assign left_drive_o  = left_q;

  // ---- assertions ----
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o) else $error("accepted while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(right_drive_o)))
    else $error("result dropped while stalled");
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MIX) |-> (tout_q <= ClampLim && tout_q >= -ClampLim))
    else $error("loop output out of range");

endmodule
